@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by utf8_stream_decoder_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ rtl/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Widths and lookup functions for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int ByteW  = 8;
  localparam int CpW    = 31;
  localparam int CountW = 3;
  localparam int OnesW  = 4;

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;
  localparam logic [ByteW-1:0] LeadMask  = 8'h7F;
  localparam logic [CpW-1:0]   CpMaxAll  = 31'h7FFFFFFF;

  // largest value that a sequence with one fewer continuation byte can carry
  function automatic logic [CpW-1:0] shortest_max(input logic [CountW-1:0] extra);
    logic [CpW-1:0] lim;
    unique case (extra)
      3'd1:    lim = 31'h0000007F;
      3'd2:    lim = 31'h000007FF;
      3'd3:    lim = 31'h0000FFFF;
      3'd4:    lim = 31'h001FFFFF;
      3'd5:    lim = 31'h03FFFFFF;
      default: lim = CpMaxAll;
    endcase
    return lim;
  endfunction

  // count of leading one bits of a byte
  function automatic logic [OnesW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [OnesW-1:0] n;
    priority casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/u8sd_ifs.sv @@
// ----------------------------------------------------------------------------
// u8sd_ifs
// Valid/ready channels for string bytes and decoded results.
// ----------------------------------------------------------------------------
interface u8sd_byte_if
  import u8sd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface u8sd_cp_if
  import u8sd_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           is_end;
  logic           failed;

  modport source(output valid, output code_point, output is_end, output failed,
                 input ready);
  modport sink(input valid, input code_point, input is_end, input failed,
               output ready);
endinterface

@@ rtl/utf8_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial decoder for zero-terminated strings in legacy UTF-8.
// ----------------------------------------------------------------------------
// Takes one byte per beat and returns at most one result beat per byte: a
// code point when a one- to six-byte sequence completes, or an end beat with
// the string's failure flag for the zero byte. Malformed leads, bad
// continuations and overlong forms fail the string and silence it until the
// zero byte. A byte is accepted every cycle while the result register is
// empty or being drained; a result appears in the cycle after its last byte and
// waits in the result register, so throughput is one byte per cycle and is
// set only by the readiness of the result side.

`include "assert_macros.svh"

module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  u8sd_byte_if.sink  byte_stream,
  u8sd_cp_if.source  cp_stream
);

  logic [CountW-1:0] bytes_left, bytes_left_next;
  logic [CountW-1:0] seq_len_extra, seq_len_extra_next;
  logic [CpW-1:0]    accum_value, accum_value_next;
  logic              string_failed, string_failed_next;

  logic              res_valid;
  logic [CpW-1:0]    res_cp, res_cp_next;
  logic              res_end, res_end_next;
  logic              res_fail, res_fail_next;

  logic              accept;
  logic              emit;
  logic [ByteW-1:0]  b;
  logic [OnesW-1:0]  ones;
  logic [CpW-1:0]    cont_value;

  assign byte_stream.ready = !res_valid || cp_stream.ready;
  assign accept            = byte_stream.valid && byte_stream.ready;
  assign b                 = byte_stream.in_byte;
  assign ones              = lead_ones(b);
  assign cont_value        = {accum_value[CpW-7:0], b[5:0]};

  always_comb begin
    bytes_left_next    = bytes_left;
    seq_len_extra_next = seq_len_extra;
    accum_value_next   = accum_value;
    string_failed_next = string_failed;
    emit               = 1'b0;
    res_cp_next        = res_cp;
    res_end_next       = res_end;
    res_fail_next      = res_fail;
    if (accept) begin
      if (b == '0) begin
        emit               = 1'b1;
        res_cp_next        = '0;
        res_end_next       = 1'b1;
        res_fail_next      = string_failed || (bytes_left != '0);
        bytes_left_next    = '0;
        seq_len_extra_next = '0;
        accum_value_next   = '0;
        string_failed_next = 1'b0;
      end else if (!string_failed) begin
        if (bytes_left == '0) begin
          if (ones == '0) begin
            emit          = 1'b1;
            res_cp_next   = CpW'(b);
            res_end_next  = 1'b0;
            res_fail_next = 1'b0;
          end else if (ones == 4'd1 || ones >= 4'd7) begin
            string_failed_next = 1'b1;
            seq_len_extra_next = '0;
            accum_value_next   = '0;
          end else begin
            accum_value_next   = CpW'(b & (LeadMask >> ones));
            bytes_left_next    = CountW'(ones - 4'd1);
            seq_len_extra_next = CountW'(ones - 4'd1);
          end
        end else if ((b & ContMask) != ContMark) begin
          string_failed_next = 1'b1;
          bytes_left_next    = '0;
          seq_len_extra_next = '0;
          accum_value_next   = '0;
        end else begin
          bytes_left_next  = CountW'(bytes_left - 3'd1);
          accum_value_next = cont_value;
          if (bytes_left == 3'd1) begin
            seq_len_extra_next = '0;
            accum_value_next   = '0;
            if (cont_value <= shortest_max(seq_len_extra)) begin
              string_failed_next = 1'b1;
            end else begin
              emit          = 1'b1;
              res_cp_next   = cont_value;
              res_end_next  = 1'b0;
              res_fail_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      seq_len_extra <= '0;
      accum_value   <= '0;
      string_failed <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      bytes_left    <= bytes_left_next;
      seq_len_extra <= seq_len_extra_next;
      accum_value   <= accum_value_next;
      string_failed <= string_failed_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (cp_stream.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_cp   <= res_cp_next;
    res_end  <= res_end_next;
    res_fail <= res_fail_next;
  end

  assign cp_stream.valid      = res_valid;
  assign cp_stream.code_point = res_cp;
  assign cp_stream.is_end     = res_end;
  assign cp_stream.failed     = res_fail;

  `ASSERT_SAME(a_left_within_len, clk, rst, 1'b1, bytes_left <= seq_len_extra)
  `ASSERT_SAME(a_failed_idle_seq, clk, rst, string_failed, bytes_left == '0)
  `ASSERT_SAME(a_cp_not_failed, clk, rst, res_valid && !res_end, !res_fail)
  `ASSERT_NEXT(a_end_clears, clk, rst, accept && b == '0,
               bytes_left == '0 && !string_failed && res_valid && res_end)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Feeds zero-terminated strings one byte per beat. A short fixed string set
// comes first, then random strings: mostly well-formed code points of every
// length, some with injected faults. The bench predicts each decoded code
// point and end beat and checks them in order on the result channel, under
// several patterns of sender gaps and receiver stalls.

module tb;
  import u8sd_pkg::*;

  typedef logic [ByteW-1:0] octet_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_end;
    logic           failed;
  } decoded_t;

  typedef enum int {
    FLT_NONE, FLT_OVERLONG, FLT_TRUNC, FLT_STRAY, FLT_HIGH_LEAD, FLT_BAD_CONT, FLT_NOISE
  } fault_t;

  localparam octet_t StrEnd = 8'h00;

  localparam octet_t DirectedBytes [28] = '{
    8'h00,
    8'h7F, 8'hC2, 8'h80, 8'h00,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00,
    8'hC1, 8'hBF, 8'h00,
    8'h80, 8'h41, 8'h00,
    8'hFF, 8'h00,
    8'hFE, 8'h00,
    8'hC3, 8'h41, 8'h00,
    8'hE2, 8'h82, 8'h00
  };

  localparam logic [CpW-1:0] CpLo [1:6] = '{
    31'h1, 31'h80, 31'h800, 31'h10000, 31'h200000, 31'h4000000
  };
  localparam logic [CpW-1:0] CpHi [1:6] = '{
    31'h7F, 31'h7FF, 31'hFFFF, 31'h1FFFFF, 31'h3FFFFFF, 31'h7FFFFFFF
  };

  localparam int SrcIdle [4]  = '{0, 53, 0, 24};
  localparam int SnkStall [4] = '{0, 0, 53, 24};
  localparam int PhaseBytes   = 225;
  localparam int HoldCycles   = 150;

  class decode_scoreboard;
    decoded_t         expected_q[$];
    int               mismatches;
    logic [2:0]       cont_left;
    logic [2:0]       cont_total;
    logic [CpW-1:0]   acc;
    bit               str_bad;

    function new();
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      cont_left  = '0;
      cont_total = '0;
      acc        = '0;
      str_bad    = 1'b0;
    endfunction

    function void fail_string();
      clear_string();
      str_bad = 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(octet_t b);
      int             ones;
      decoded_t       r;
      logic [CpW-1:0] lim;
      if (b == StrEnd) begin
        r.code_point = '0;
        r.is_end     = 1'b1;
        r.failed     = str_bad || (cont_left != 0);
        expected_q.push_back(r);
        clear_string();
        return;
      end
      if (str_bad) return;
      if (cont_left == 0) begin
        ones = 0;
        while (ones < 8 && b[7-ones]) ones++;
        if (ones == 0) begin
          r.code_point = CpW'(b);
          r.is_end     = 1'b0;
          r.failed     = 1'b0;
          expected_q.push_back(r);
        end else if (ones == 1 || ones >= 7) begin
          fail_string();
        end else begin
          acc        = CpW'(b & (8'h7F >> ones));
          cont_left  = 3'(ones - 1);
          cont_total = 3'(ones - 1);
        end
        return;
      end
      if (b[7:6] != 2'b10) begin
        fail_string();
        return;
      end
      acc       = {acc[CpW-7:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left != 0) return;
      case (cont_total)
        3'd1:    lim = 31'h7F;
        3'd2:    lim = 31'h7FF;
        3'd3:    lim = 31'hFFFF;
        3'd4:    lim = 31'h1FFFFF;
        3'd5:    lim = 31'h3FFFFFF;
        default: lim = '1;
      endcase
      r.code_point = acc;
      r.is_end     = 1'b0;
      r.failed     = 1'b0;
      cont_total   = '0;
      acc          = '0;
      if (r.code_point <= lim) fail_string();
      else expected_q.push_back(r);
    endfunction

    function void check_result(logic [CpW-1:0] cp, logic is_end, logic failed);
      decoded_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result cp=%h end=%b failed=%b", $time, cp, is_end, failed);
        return;
      end
      want = expected_q.pop_front();
      if (want.code_point !== cp || want.is_end !== is_end || want.failed !== failed) begin
        mismatches++;
        $display("%0t: expected cp=%h end=%b failed=%b, actual cp=%h end=%b failed=%b",
                 $time, want.code_point, want.is_end, want.failed, cp, is_end, failed);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  u8sd_byte_if byte_bus ();
  u8sd_cp_if   cp_bus ();

  utf8_stream_decoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_bus),
    .cp_stream   (cp_bus)
  );

  decode_scoreboard sb;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void add_char(ref octet_t q[$], input logic [CpW-1:0] cp, input int n);
    octet_t lead;
    if (n == 1) begin
      q.push_back({1'b0, cp[6:0]});
      return;
    end
    lead = (8'hFF << (8 - n)) | (8'(cp >> (6 * (n - 1))) & (8'h7F >> n));
    q.push_back(lead);
    for (int k = n - 2; k >= 0; k--) q.push_back(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
  endfunction

  function automatic void build_string(ref octet_t q[$]);
    octet_t         tmp[$];
    octet_t         bad;
    logic [CpW-1:0] cp;
    fault_t         fault;
    int             nchars, pos, n, r, keep;
    nchars = $urandom_range(6, 0);
    pos    = $urandom_range(nchars, 0);
    fault  = ($urandom_range(99) < 70) ? FLT_NONE : fault_t'($urandom_range(6, 1));
    for (int i = 0; i <= nchars; i++) begin
      if (i == pos) begin
        tmp.delete();
        n = $urandom_range(6, 2);
        case (fault)
          FLT_OVERLONG: add_char(q, CpW'($urandom_range(CpHi[n-1], 0)), n);
          FLT_TRUNC: begin
            add_char(tmp, CpW'($urandom_range(CpHi[n], CpLo[n])), n);
            keep = $urandom_range(n - 1, 1);
            for (int j = 0; j < keep; j++) q.push_back(tmp[j]);
          end
          FLT_STRAY:     q.push_back(8'h80 | 8'($urandom_range(63)));
          FLT_HIGH_LEAD: q.push_back($urandom_range(1) ? 8'hFE : 8'hFF);
          FLT_BAD_CONT: begin
            add_char(tmp, CpW'($urandom_range(CpHi[n], CpLo[n])), n);
            do bad = 8'($urandom_range(255, 1)); while (bad[7:6] == 2'b10);
            tmp[$urandom_range(n - 1, 1)] = bad;
            foreach (tmp[j]) q.push_back(tmp[j]);
          end
          FLT_NOISE: begin
            repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255, 1)));
          end
          default: ;
        endcase
      end
      if (i < nchars) begin
        r = $urandom_range(9);
        n = (r < 4) ? 1 : (r < 6) ? 2 : r - 3;
        r = $urandom_range(7);
        cp = (r == 0) ? CpLo[n] : (r == 1) ? CpHi[n] : CpW'($urandom_range(CpHi[n], CpLo[n]));
        add_char(q, cp, n);
      end
    end
    q.push_back(StrEnd);
  endfunction

  task automatic send_byte(input octet_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.in_byte <= b;
    do @(posedge clk); while (byte_bus.ready !== 1'b1);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  initial begin : result_sink
    cp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        cp_bus.ready <= 1'b0;
      end else begin
        cp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
      @(posedge clk);
      if (!rst && cp_bus.valid === 1'b1 && cp_bus.ready === 1'b1)
        sb.check_result(cp_bus.code_point, cp_bus.is_end, cp_bus.failed);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    octet_t str_q[$];
    int     sent;
    sb               = new();
    rst              = 1'b1;
    byte_bus.valid   = 1'b0;
    byte_bus.in_byte = '0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    hold_left        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SrcIdle[ph];
      snk_stall_pct = SnkStall[ph];
      // hold the result side off while bytes keep coming, to back up the input
      if (ph == 0) hold_left = HoldCycles;
      sent = 0;
      while (sent < PhaseBytes) begin
        str_q.delete();
        build_string(str_q);
        foreach (str_q[i]) send_byte(str_q[i]);
        sent += str_q.size();
      end
    end
    byte_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
